FILE: design/itr_pkg.sv
package itr_pkg;

    localparam int HIST_AW   = 8;
    localparam int PRICE_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int EMA_EXTRA = 8;
    localparam int SUM_W     = 40;
    localparam int DIV_W     = 64;
    localparam int DVSR_W    = 40;

    // 100.0 in Q16.16
    localparam logic [22:0] RSI_TOP = 23'd6553600;

    localparam logic [2:0] KIND_PRICE = 3'd0;
    localparam logic [2:0] KIND_SMA   = 3'd1;
    localparam logic [2:0] KIND_EMA   = 3'd2;
    localparam logic [2:0] KIND_RSI   = 3'd3;
    localparam logic [2:0] KIND_BAND  = 3'd4;

    localparam logic [1:0] BAND_LOWER  = 2'd0;
    localparam logic [1:0] BAND_MIDDLE = 2'd1;
    localparam logic [1:0] BAND_UPPER  = 2'd2;
    localparam logic [1:0] BAND_ALIAS  = 2'd3;

    localparam logic [2:0] CFG_KIND   = 3'd0;
    localparam logic [2:0] CFG_CMP_GT = 3'd1;
    localparam logic [2:0] CFG_WINDOW = 3'd2;
    localparam logic [2:0] CFG_THRESH = 3'd3;
    localparam logic [2:0] CFG_BMULT  = 3'd4;
    localparam logic [2:0] CFG_BSEL   = 3'd5;

    typedef struct packed {
        logic [31:0] price;
        logic        restart;
    } t_in;

    typedef struct packed {
        logic        signal;
        logic [31:0] indicator_value;
        logic        warmed_up;
    } t_out;

    typedef struct packed {
        logic [2:0]  kind;
        logic        cmp_gt;
        logic [7:0]  window;
        logic [31:0] threshold;
        logic [23:0] band_mult;
        logic [1:0]  band_sel;
    } t_cfg;

    typedef struct packed {
        logic [31:0] price;
        logic        restart;
        logic [7:0]  n;
        logic [2:0]  kind;
        logic [1:0]  band_sel;
    } t_item;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_SEED, S_SEED_W, S_EMA, S_EMA_W, S_RSI, S_RSI_W,
        S_BAND, S_VSCAN, S_VAR, S_VAR_W, S_SQRT, S_SQRT_W, S_OFF, S_BVAL, S_DONE
    } t_bstate;

endpackage

FILE: design/indicator_threshold_rule_core.sv
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_in_data  (price, restart)
// result    out        o_out_valid / i_out_ready  o_out_data (signal, indicator_value, warmed_up)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item takes the handshake, the window scan of n+1 reads and the steps, plus one
// division each for the window mean once n days exist, the exponential update once
// it is seeded, and for the strength index one more when the window has losses.
// Lower and upper bands add a second scan, a division and a square root; every
// division runs in the one divider.
// Reset is synchronous and active low; it clears the series and returns the configuration to its defaults.
// A two-entry queue takes items while the back end works, and the result register
// holds a finished result until it is taken; a full result register stalls the back end.
module indicator_threshold_rule_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  itr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output itr_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import itr_pkg::*;

    t_cfg  r_cfg;
    t_item q_item;
    logic  q_valid;
    logic  q_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kind      <= KIND_PRICE;
            r_cfg.cmp_gt    <= 1'b1;
            r_cfg.window    <= 8'd14;
            r_cfg.threshold <= '0;
            r_cfg.band_mult <= 24'd131072;
            r_cfg.band_sel  <= BAND_MIDDLE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KIND:   r_cfg.kind      <= i_cfg_data[2:0];
                CFG_CMP_GT: r_cfg.cmp_gt    <= i_cfg_data[0];
                CFG_WINDOW: r_cfg.window    <= i_cfg_data[7:0];
                CFG_THRESH: r_cfg.threshold <= i_cfg_data;
                CFG_BMULT:  r_cfg.band_mult <= i_cfg_data[23:0];
                CFG_BSEL:   r_cfg.band_sel  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    itr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_item   (q_item)
    );

    itr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .i_cfg       (r_cfg),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: design/itr_div.sv
module itr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [39:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quotient
);
    import itr_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;
    logic [DIV_W-1:0]  r_quo;
    logic [DVSR_W:0]   rem_sh;
    logic              take;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign take   = rem_sh >= {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
                r_rem  <= '0;
                r_dvsr <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                // The remainder stays below the divisor, so it fits the divisor width.
                r_rem <= take ? DVSR_W'(rem_sh - {1'b0, r_dvsr}) : rem_sh[DVSR_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], take};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/itr_sqrt.sv
module itr_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_root
);
    import itr_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_x;
                r_res  <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
            end else if (r_busy) begin
                if (r_x >= trial) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == 64'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

FILE: design/itr_front.sv
module itr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  itr_pkg::t_in    i_in_data,
    input  itr_pkg::t_cfg   i_cfg,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output itr_pkg::t_item  o_q_item
);
    import itr_pkg::*;

    t_item      cls;
    t_item      r_entry [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    // Fold out-of-range settings onto the codes that behave the same.
    always_comb begin
        cls.price    = i_in_data.price;
        cls.restart  = i_in_data.restart;
        cls.n        = (i_cfg.window == '0) ? 8'd1 : i_cfg.window;
        cls.kind     = (i_cfg.kind > KIND_BAND) ? KIND_PRICE : i_cfg.kind;
        cls.band_sel = (i_cfg.band_sel == BAND_ALIAS) ? BAND_LOWER : i_cfg.band_sel;
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_q_valid && i_q_ready;
    assign o_q_item   = r_entry[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_entry[r_wptr] <= cls;
                r_wptr          <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: design/itr_back.sv
module itr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  itr_pkg::t_item  i_q_item,
    input  itr_pkg::t_cfg   i_cfg,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output itr_pkg::t_out   o_out_data
);
    import itr_pkg::*;

    localparam logic [8:0] DAY_MAX = 9'd256;

    t_bstate r_state;
    t_bstate n_state;

    logic [31:0] mem [1 << HIST_AW];

    t_item             r_item;
    logic [HIST_AW-1:0] r_wp;
    logic [8:0]        r_day;
    logic              r_seeded;
    logic [SUM_W-1:0]  r_ema;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_gain;
    logic [SUM_W-1:0]  r_loss;
    logic [8:0]        r_k;
    logic              r_dv;
    logic [8:0]        r_dk;
    logic [31:0]       r_rd;
    logic [31:0]       r_last;
    logic [31:0]       r_mean;
    logic [SUM_W-1:0]  r_seed;
    logic [47:0]       r_ema_mul;
    logic [62:0]       r_rsi_mul;
    logic [31:0]       r_rsi;
    logic [63:0]       r_sq;
    logic              r_pv;
    logic [8:0]        r_pk;
    logic [55:0]       r_s;
    logic [47:0]       r_var;
    logic [31:0]       r_dev;
    logic [SUM_W-1:0]  r_off;
    logic [31:0]       r_band;
    logic              r_out_valid;
    t_out              r_out;

    logic [8:0]        n9;
    logic [7:0]        nm1;
    logic              warm_n;
    logic              warm_n1;
    logic [HIST_AW-1:0] rd_addr;
    logic              issue;
    logic              scan_done;
    logic              vscan_done;
    logic              pop;
    logic              out_free;
    logic              rsi_go;
    logic              band_go;
    logic [48:0]       ema_num;
    logic [31:0]       dif;
    logic [40:0]       up_sum;
    logic [55:0]       off_prod;

    logic              div_start;
    logic [63:0]       div_dividend;
    logic [39:0]       div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [63:0]       div_q;
    logic              sqrt_start;
    logic              sqrt_busy;
    logic              sqrt_done;
    logic [31:0]       sqrt_root;

    t_out              res;
    logic              res_warm;
    logic [31:0]       res_val;
    logic [31:0]       lhs;
    logic [31:0]       rhs;

    assign n9        = {1'b0, r_item.n};
    assign nm1       = r_item.n - 8'd1;
    assign warm_n    = r_day >= n9;
    assign warm_n1   = r_day >= (n9 + 9'd1);
    assign rd_addr   = r_wp - HIST_AW'(1) - r_k[HIST_AW-1:0];
    assign scan_done = r_dv && (r_dk == n9);
    assign vscan_done = r_pv && (r_pk == (n9 - 9'd1));
    assign out_free  = !r_out_valid || i_out_ready;
    assign rsi_go    = (r_item.kind == KIND_RSI) && warm_n1 && (r_loss != '0);
    assign band_go   = (r_item.kind == KIND_BAND) && warm_n && (r_item.band_sel != BAND_MIDDLE);
    assign ema_num   = {8'd0, r_item.price, 9'd0} + {1'b0, r_ema_mul};
    assign dif       = (r_rd > r_mean) ? (r_rd - r_mean) : (r_mean - r_rd);
    assign up_sum    = {9'd0, r_mean} + {1'b0, r_off};
    assign off_prod  = i_cfg.band_mult * r_dev;

    itr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    itr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     ({r_var, 16'd0}),
        .o_busy  (sqrt_busy),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_q_valid) n_state = S_SCAN;
            S_SCAN:   if (scan_done) n_state = S_SEED;
            S_SEED:   n_state = warm_n ? S_SEED_W : S_EMA;
            S_SEED_W: if (div_done) n_state = S_EMA;
            S_EMA:    n_state = r_seeded ? S_EMA_W : S_RSI;
            S_EMA_W:  if (div_done) n_state = S_RSI;
            S_RSI:    n_state = rsi_go ? S_RSI_W : S_BAND;
            S_RSI_W:  if (div_done) n_state = S_BAND;
            S_BAND:   n_state = band_go ? S_VSCAN : S_DONE;
            S_VSCAN:  if (vscan_done) n_state = S_VAR;
            S_VAR:    n_state = S_VAR_W;
            S_VAR_W:  if (div_done) n_state = S_SQRT;
            S_SQRT:   n_state = S_SQRT_W;
            S_SQRT_W: if (sqrt_done) n_state = S_OFF;
            S_OFF:    n_state = S_BVAL;
            S_BVAL:   n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_ready    = 1'b0;
        issue        = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        sqrt_start   = 1'b0;
        case (r_state)
            S_IDLE: o_q_ready = 1'b1;
            S_SCAN: issue = (r_k <= n9);
            S_SEED: begin
                div_start    = warm_n;
                div_dividend = {16'd0, r_sum, 8'd0};
                div_divisor  = {32'd0, r_item.n};
            end
            S_EMA: begin
                div_start    = r_seeded;
                div_dividend = {15'd0, ema_num};
                div_divisor  = {31'd0, n9 + 9'd1};
            end
            S_RSI: begin
                div_start    = rsi_go;
                div_dividend = {1'b0, r_rsi_mul};
                div_divisor  = r_gain + r_loss;
            end
            S_VSCAN: issue = (r_k < n9);
            S_VAR: begin
                div_start    = 1'b1;
                div_dividend = {8'd0, r_s};
                div_divisor  = {32'd0, r_item.n};
            end
            S_SQRT: sqrt_start = 1'b1;
            default: ;
        endcase
    end

    assign pop = o_q_ready && i_q_valid;

    always_comb begin
        case (r_item.kind)
            KIND_SMA: begin
                res_warm = warm_n;
                res_val  = r_mean;
            end
            KIND_EMA: begin
                res_warm = r_seeded && warm_n;
                res_val  = r_ema[SUM_W-1:EMA_EXTRA];
            end
            KIND_RSI: begin
                res_warm = warm_n1;
                res_val  = r_rsi;
            end
            KIND_BAND: begin
                res_warm = warm_n;
                res_val  = (r_item.band_sel == BAND_MIDDLE) ? r_mean : r_band;
            end
            default: begin
                res_warm = 1'b1;
                res_val  = r_item.price;
            end
        endcase
        // Bands compare the price against the band; the rest compare the level.
        lhs = (r_item.kind == KIND_BAND) ? r_item.price : res_val;
        rhs = (r_item.kind == KIND_BAND) ? res_val : i_cfg.threshold;
        res.signal          = res_warm && (i_cfg.cmp_gt ? (lhs > rhs) : (lhs < rhs));
        res.indicator_value = res_warm ? res_val : '0;
        res.warmed_up       = res_warm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            mem[r_wp] <= i_q_item.price;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_day       <= '0;
            r_seeded    <= 1'b0;
            r_ema       <= '0;
            r_k         <= '0;
            r_dv        <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ema_mul <= nm1 * r_ema;
            r_rsi_mul <= RSI_TOP * r_gain;
            // In the finishing state the result register is reloaded below instead.
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_item <= i_q_item;
                        r_wp   <= r_wp + HIST_AW'(1);
                        if (i_q_item.restart) begin
                            r_day    <= 9'd1;
                            r_seeded <= 1'b0;
                            r_ema    <= '0;
                        end else if (r_day < DAY_MAX) begin
                            r_day <= r_day + 9'd1;
                        end
                        r_k    <= '0;
                        r_dv   <= 1'b0;
                        r_sum  <= '0;
                        r_gain <= '0;
                        r_loss <= '0;
                    end
                end
                S_SCAN: begin
                    r_dv <= issue;
                    r_dk <= r_k;
                    if (issue) r_k <= r_k + 9'd1;
                    // Data for index k is the price k days back; pairs give the changes.
                    if (r_dv) begin
                        r_last <= r_rd;
                        if (r_dk < n9) r_sum <= r_sum + SUM_W'(r_rd);
                        if (r_dk != '0) begin
                            if (r_last > r_rd) r_gain <= r_gain + SUM_W'(r_last - r_rd);
                            else               r_loss <= r_loss + SUM_W'(r_rd - r_last);
                        end
                    end
                end
                S_SEED_W: begin
                    if (div_done) begin
                        r_seed <= div_q[SUM_W-1:0];
                        r_mean <= div_q[SUM_W-1:EMA_EXTRA];
                    end
                end
                S_EMA: begin
                    if (!r_seeded && warm_n) begin
                        r_ema    <= r_seed;
                        r_seeded <= 1'b1;
                    end
                end
                S_EMA_W: begin
                    if (div_done) r_ema <= div_q[SUM_W-1:0];
                end
                S_RSI: r_rsi <= {9'd0, RSI_TOP};
                S_RSI_W: begin
                    if (div_done) r_rsi <= div_q[31:0];
                end
                S_BAND: begin
                    r_k  <= '0;
                    r_dv <= 1'b0;
                    r_pv <= 1'b0;
                    r_s  <= '0;
                end
                S_VSCAN: begin
                    r_dv <= issue;
                    r_dk <= r_k;
                    if (issue) r_k <= r_k + 9'd1;
                    r_pv <= r_dv;
                    r_pk <= r_dk;
                    if (r_dv) r_sq <= dif * dif;
                    // Each term is below 2^48, so 255 of them never reach the top.
                    if (r_pv) r_s <= r_s + 56'(r_sq[63:FRAC_BITS]);
                end
                S_VAR_W: begin
                    if (div_done) r_var <= div_q[47:0];
                end
                S_SQRT_W: begin
                    if (sqrt_done) r_dev <= sqrt_root;
                end
                S_OFF: r_off <= off_prod[55:16];
                S_BVAL: begin
                    if (r_item.band_sel == BAND_UPPER) begin
                        r_band <= (up_sum[40:32] != '0) ? 32'hFFFF_FFFF : up_sum[31:0];
                    end else begin
                        r_band <= (r_off >= {8'd0, r_mean}) ? 32'd0 : (r_mean - r_off[31:0]);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out       <= res;
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_day_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_day <= DAY_MAX)
        else $error("day count ran past the history depth");

    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_sqrt_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("square root started while busy");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k <= (n9 + 9'd1)))
        else $error("window scan read past the window");

endmodule

FILE: verif/tb_indicator_threshold_rule_core.sv
`timescale 1ns / 100ps
module tb_indicator_threshold_rule_core;
    import itr_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    t_in         in_data = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_out        o_out_data;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  cfg_index = CFG_KIND;
    logic [31:0] cfg_data = '0;

    indicator_threshold_rule_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Mirror of the block's configuration and series state.
    logic [2:0]  m_kind = KIND_PRICE;
    logic        m_gt = 1'b1;
    logic [7:0]  m_win = 8'd14;
    logic [31:0] m_thr = '0;
    logic [23:0] m_bmult = 24'd131072;
    logic [1:0]  m_bsel = BAND_MIDDLE;

    logic [31:0] hist [256];
    logic [7:0]  wpos = '0;
    int unsigned days = 0;
    logic [63:0] win_sum = '0, ema = '0, gain = '0, loss = '0;
    bit          ema_seeded = 0;

    t_in  days_pending [$];
    t_out rule_expected [$];
    t_out day_pred;
    t_out seen_pred;
    int   mismatches = 0;
    int   gap_left = 0;
    int   burst_left = 10;
    int   stall_mode = 0;
    int   stall_left = 0;
    int   hold_cnt = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    logic [31:0] level = 32'h0064_0000;

    function automatic logic [31:0] back(int k);
        return hist[8'(wpos - 8'd1 - 8'(k))];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res, b;
        res = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    task automatic rule_for_day(input t_in it, output t_out r);
        logic [63:0]  p, value, ref_lvl, m, s, sq, d, x, var_q, scaled, dev, off, lhs, top;
        logic [127:0] prod;
        int           n, k;
        bit           warm;
        p = 64'(it.price);
        n = m_win;
        value = '0;
        ref_lvl = 64'(m_thr);
        warm = 0;
        if (it.restart) begin
            days = 0;
            ema_seeded = 0;
            win_sum = '0;
            ema = '0;
            gain = '0;
            loss = '0;
        end
        hist[wpos] = it.price;
        wpos = wpos + 8'd1;
        if (days < 256) days++;
        if (n == 0) n = 1;
        if (days >= n) begin
            win_sum = '0;
            for (k = 0; k < n; k++) win_sum += 64'(back(k));
        end
        if (days >= n + 1) begin
            gain = '0;
            loss = '0;
            for (k = 0; k < n; k++) begin
                if (back(k) > back(k + 1)) gain += 64'(back(k) - back(k + 1));
                else loss += 64'(back(k + 1) - back(k));
            end
        end
        if (!ema_seeded) begin
            if (days >= n) begin
                ema = (win_sum << EMA_EXTRA) / 64'(n);
                ema_seeded = 1;
            end
        end else begin
            ema = ((p << EMA_EXTRA) * 64'd2 + 64'(n - 1) * ema) / 64'(n + 1);
        end
        case (m_kind)
            KIND_SMA: begin
                warm = days >= n;
                if (warm) value = win_sum / 64'(n);
            end
            KIND_EMA: begin
                warm = ema_seeded && days >= n;
                if (warm) value = ema >> EMA_EXTRA;
            end
            KIND_RSI: begin
                warm = days >= n + 1;
                if (warm) begin
                    top = 64'd100 << FRAC_BITS;
                    if (loss == 0) begin
                        value = top;
                    end else begin
                        prod = 128'(top) * 128'(gain);
                        value = 64'(prod / 128'(gain + loss));
                    end
                end
            end
            KIND_BAND: begin
                warm = days >= n;
                if (warm) begin
                    m = win_sum / 64'(n);
                    value = m;
                    if (m_bsel != BAND_MIDDLE) begin
                        s = '0;
                        for (k = 0; k < n; k++) begin
                            x = 64'(back(k));
                            d = (x > m) ? x - m : m - x;
                            sq = (d * d) >> FRAC_BITS;
                            s = (s > ~64'd0 - sq) ? ~64'd0 : s + sq;
                        end
                        var_q = s / 64'(n);
                        scaled = var_q << FRAC_BITS;
                        dev = int_sqrt(scaled);
                        off = (64'(m_bmult) * dev) >> 16;
                        if (m_bsel == BAND_UPPER)
                            value = (m + off > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : m + off;
                        else
                            value = (off >= m) ? 64'd0 : m - off;
                    end
                    ref_lvl = value;
                end
            end
            default: begin
                warm = 1;
                value = p;
            end
        endcase
        if (value > 64'hFFFF_FFFF) value = 64'hFFFF_FFFF;
        r = '0;
        if (warm) begin
            lhs = (m_kind == KIND_BAND) ? p : value;
            r.signal = m_gt ? (lhs > ref_lvl) : (lhs < ref_lvl);
            r.indicator_value = value[31:0];
            r.warmed_up = 1'b1;
        end
    endtask

    // Sender: bursts of transfers separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                rule_for_day(in_data, day_pred);
                rule_expected = {rule_expected, day_pred};
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (days_pending.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data <= days_pending.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that changes mode, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (out_ready && o_out_valid) begin
            if (rule_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", o_out_data);
            end else begin
                seen_pred = rule_expected.pop_front();
                if (o_out_data.signal !== seen_pred.signal
                        || o_out_data.indicator_value !== seen_pred.indicator_value
                        || o_out_data.warmed_up !== seen_pred.warmed_up) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("result mismatch: expected sig=%0d val=%h warm=%0d",
                               seen_pred.signal, seen_pred.indicator_value,
                               seen_pred.warmed_up);
                        $display(", got sig=%0d val=%h warm=%0d",
                                 o_out_data.signal, o_out_data.indicator_value,
                                 o_out_data.warmed_up);
                    end
                end
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= 600;
            out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_left <= $urandom_range(64, 300);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_KIND:   m_kind = value[2:0];
            CFG_CMP_GT: m_gt = value[0];
            CFG_WINDOW: m_win = value[7:0];
            CFG_THRESH: m_thr = value;
            CFG_BMULT:  m_bmult = value[23:0];
            CFG_BSEL:   m_bsel = value[1:0];
            default: ;
        endcase
    endtask

    task automatic setup(input logic [2:0] kind, input logic gt, input logic [7:0] win,
                         input logic [31:0] thr, input logic [23:0] bmult,
                         input logic [1:0] bsel);
        write_reg(CFG_KIND, 32'(kind));
        write_reg(CFG_CMP_GT, 32'(gt));
        write_reg(CFG_WINDOW, 32'(win));
        write_reg(CFG_THRESH, thr);
        write_reg(CFG_BMULT, 32'(bmult));
        write_reg(CFG_BSEL, 32'(bsel));
        cfg_valid <= 1'b0;
    endtask

    task automatic add_day(input logic [31:0] price, input logic restart);
        t_in it;
        it.price = price;
        it.restart = restart;
        days_pending = {days_pending, it};
    endtask

    task automatic drain();
        while (days_pending.size() != 0 || in_valid || rule_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] next_price();
        int step;
        case ($urandom_range(0, 19))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom;
            4: return level;
            default: begin
                step = int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
                if (step < 0 && level < 32'(-step)) level = 32'h0001_0000;
                else if (step > 0 && level > 32'hFFFF_FFFF - 32'(step)) level = 32'hFFF0_0000;
                else level = level + 32'(step);
                return level;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_thr();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3: return $urandom_range(0, 100) << FRAC_BITS;
            default: return level + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    initial begin
        int ph, i, nitems;
        logic [2:0] kind;
        logic [7:0] win;
        logic [23:0] bm;
        for (i = 0; i < 256; i++) hist[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Raw price at the extremes, window zero acting as one.
        setup(KIND_PRICE, 1'b1, 8'd0, 32'h8000_0000, 24'd131072, BAND_MIDDLE);
        add_day(32'd0, 1'b1);
        add_day(32'hFFFF_FFFF, 1'b0);
        add_day(32'h8000_0000, 1'b0);
        add_day(32'h8000_0001, 1'b1);
        drain();
        // Unknown kind codes fall back to the raw price.
        setup(3'd7, 1'b0, 8'd255, 32'h0001_0000, 24'd0, BAND_LOWER);
        add_day(32'h0000_FFFF, 1'b0);
        add_day(32'h0001_0000, 1'b0);
        drain();
        // Strength index: flat prices give no losses, then a falling run.
        setup(KIND_RSI, 1'b1, 8'd2, 32'h0031_0000, 24'd0, BAND_MIDDLE);
        add_day(32'h0010_0000, 1'b1);
        add_day(32'h0010_0000, 1'b0);
        add_day(32'h0010_0000, 1'b0);
        add_day(32'h000F_0000, 1'b0);
        add_day(32'h000E_0000, 1'b0);
        drain();
        // Band code three as the lower band, saturated at zero.
        setup(KIND_BAND, 1'b0, 8'd3, 32'd0, 24'hFF_FFFF, BAND_ALIAS);
        add_day(32'd0, 1'b1);
        add_day(32'hFFFF_FFFF, 1'b0);
        add_day(32'd0, 1'b0);
        drain();
        // Upper band saturated at the top.
        setup(KIND_BAND, 1'b1, 8'd3, 32'd0, 24'hFF_FFFF, BAND_UPPER);
        add_day(32'hFFFF_FFFF, 1'b0);
        add_day(32'hFFFF_0000, 1'b0);
        drain();
        // Averages on a one-day window and a two-day window.
        setup(KIND_EMA, 1'b1, 8'd1, 32'h0005_0000, 24'd131072, BAND_MIDDLE);
        add_day(32'h0005_0000, 1'b0);
        add_day(32'h0006_0000, 1'b0);
        drain();
        setup(KIND_SMA, 1'b0, 8'd2, 32'h0006_0000, 24'd131072, BAND_MIDDLE);
        add_day(32'h0007_0000, 1'b0);
        add_day(32'h0004_0000, 1'b0);
        drain();

        // Widest window: warm up the bands, then the strength index on the same series.
        setup(KIND_BAND, 1'b1, 8'd255, 32'd0, 24'd131072, BAND_UPPER);
        add_day(next_price(), 1'b1);
        for (i = 0; i < 259; i++) add_day(next_price(), 1'b0);
        drain();
        setup(KIND_RSI, 1'b0, 8'd255, 32'h0032_0000, 24'd131072, BAND_LOWER);
        for (i = 0; i < 20; i++) add_day(next_price(), 1'b0);
        drain();

        for (ph = 0; ph < 15; ph++) begin
            kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            case ($urandom_range(0, 9))
                0: win = 8'd0;
                1: win = 8'd1;
                2: win = 8'd2;
                3: win = 8'($urandom_range(20, 60));
                default: win = 8'($urandom_range(3, 20));
            endcase
            case ($urandom_range(0, 3))
                0: bm = 24'd0;
                1: bm = 24'hFF_FFFF;
                2: bm = 24'($urandom);
                default: bm = 24'd131072;
            endcase
            setup(kind, 1'($urandom_range(0, 1)), win, pick_thr(), bm,
                  2'($urandom_range(0, 3)));
            if (ph == 5) hold_req++;
            nitems = $urandom_range(48, 68);
            for (i = 0; i < nitems; i++)
                add_day(next_price(), ($urandom_range(0, 49) == 0));
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && rule_expected.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/itr_pkg.sv
design/itr_div.sv
design/itr_sqrt.sv
design/itr_front.sv
design/itr_back.sv
design/indicator_threshold_rule_core.sv
verif/tb_indicator_threshold_rule_core.sv
